// ===== hw/rtl/ssr_pkg.sv =====
// Shared types and constants for the stepper speed ramp.
// Holds register indexes, reset values, field widths and state codes.
// No dependencies.
`timescale 1ns / 1ps

package ssr_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Field widths fixed by the interface.
	localparam int SPEED_W    = 16;
	localparam int DIVISOR_W  = 15;
	localparam int DEADBAND_W = 15;
	localparam int IDLE_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 8'd1;

	localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 15'd30;
	localparam logic [IDLE_W-1:0]     IDLE_LIMIT_RST = 8'd200;

	typedef enum logic [1:0] {
		DRV_NONE    = 2'd0,
		DRV_ENABLE  = 2'd1,
		DRV_DISABLE = 2'd2
	} drv_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

endpackage

// ===== hw/rtl/stepper_speed_ramp.sv =====
// Stepper speed ramp: a tick moves the speed by (target - speed) / remaining,
// or onto the target when no ticks remain. A tick with ticks remaining is worked
// in the serial divider, one quotient bit per cycle; a command or a final tick is not.
// One request is in work at a time; the next can be taken in the cycle after the result
// is posted, and a result held back by m_tready low stalls the block until it leaves.
// Reset clears the ramp state, enables the driver, loads deadband 30 and idle limit 200.
`timescale 1ns / 1ps

module stepper_speed_ramp
	import ssr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,    // ramp_ticks[15:0], target_speed[31:16]
	input  logic                  s_tuser,    // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// step_on[0], step_freq[16:1], direction[17], driver_cmd[19:18],
	// driver_enabled[20], zero pad[23:21]
	output logic [23:0]           m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW = SPEED_W + FRAC_BITS;
	localparam int NW = SW + 1;

	state_t state_q;

	logic signed [SW-1:0]      speed_q;
	logic signed [SPEED_W-1:0] target_q;
	logic [DIVISOR_W-1:0]      remaining_q;
	logic [IDLE_W-1:0]         idle_q;
	logic                      dir_q;
	logic                      en_q;
	logic [DEADBAND_W-1:0]     deadband_q;
	logic [IDLE_W-1:0]         idle_limit_q;
	logic                      op_q;
	logic                      neg_q;
	logic                      m_tvalid_q;
	logic [23:0]               m_tdata_q;

	logic                      in_acc;
	logic                      out_free;
	logic signed [SPEED_W-1:0] in_ramp;
	logic signed [NW-1:0]      diff;
	logic [NW-1:0]             diff_mag;
	logic                      div_start;
	logic                      div_done;
	logic [NW-1:0]             quo;
	logic [NW-1:0]             quo_s;

	logic [SPEED_W-1:0]        ifloor;
	logic                      frac_nz;
	logic signed [SPEED_W:0]   ispeed;
	logic signed [SPEED_W:0]   db_ext;
	logic                      pos_hit;
	logic                      neg_hit;
	logic [SPEED_W:0]          neg_ispeed;
	logic                      step_on;
	logic [SPEED_W-1:0]        step_freq;
	logic                      dir_nxt;
	logic [IDLE_W-1:0]         idle_nxt;
	logic                      en_nxt;
	drv_cmd_t                  cmd_nxt;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign in_ramp   = s_tdata[15:0];

	// Distance to the target in full precision, one bit wider than the speed.
	assign diff     = {target_q[SPEED_W-1], target_q, {FRAC_BITS{1'b0}}}
	                - {speed_q[SW-1], speed_q};
	assign diff_mag = diff[NW-1] ? NW'(-diff) : NW'(diff);

	assign div_start = in_acc && (s_tuser == OP_TICK) && (remaining_q != '0);

	ssr_div #(
		.NUM_W(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_mag),
		.divisor  (remaining_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign quo_s = neg_q ? NW'(-quo) : quo;

	// Integer speed truncated toward zero: a negative value with a nonzero
	// fraction rounds up by one from the arithmetic shift.
	assign ifloor     = speed_q[SW-1:FRAC_BITS];
	assign frac_nz    = |speed_q[FRAC_BITS-1:0];
	assign ispeed     = {ifloor[SPEED_W-1], ifloor}
	                  + {{SPEED_W{1'b0}}, speed_q[SW-1] & frac_nz};
	assign db_ext     = {2'b00, deadband_q};
	assign pos_hit    = ispeed > db_ext;
	assign neg_hit    = ispeed < -db_ext;
	assign neg_ispeed = -ispeed;
	assign step_on    = pos_hit || neg_hit;
	assign step_freq  = pos_hit ? ispeed[SPEED_W-1:0]
	                  : (neg_hit ? neg_ispeed[SPEED_W-1:0] : '0);
	assign dir_nxt    = pos_hit ? 1'b0 : (neg_hit ? 1'b1 : dir_q);

	always_comb begin
		idle_nxt = idle_q;
		en_nxt   = en_q;
		cmd_nxt  = DRV_NONE;
		if (op_q == OP_TICK) begin
			if (speed_q == '0) begin
				if (idle_q >= idle_limit_q) begin
					en_nxt  = 1'b0;
					cmd_nxt = DRV_DISABLE;
				end else begin
					idle_nxt = idle_q + 1'b1;
				end
			end else begin
				idle_nxt = '0;
				en_nxt   = 1'b1;
				cmd_nxt  = DRV_ENABLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			speed_q      <= '0;
			target_q     <= '0;
			remaining_q  <= '0;
			idle_q       <= '0;
			dir_q        <= 1'b0;
			en_q         <= 1'b1;
			deadband_q   <= DEADBAND_RST;
			idle_limit_q <= IDLE_LIMIT_RST;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DEADBAND: begin
						deadband_q <= cfg_data[DEADBAND_W-1:0];
					end
					REG_IDLE_LIMIT: begin
						idle_limit_q <= cfg_data[IDLE_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// A new result may replace one that leaves in the same cycle.
			if ((state_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == OP_LOAD) begin
							target_q    <= s_tdata[31:16];
							remaining_q <= in_ramp[SPEED_W-1] ? '0
							                                  : in_ramp[DIVISOR_W-1:0];
							state_q     <= ST_FIN;
						end else if (remaining_q == '0) begin
							speed_q <= {target_q, {FRAC_BITS{1'b0}}};
							state_q <= ST_FIN;
						end else begin
							remaining_q <= remaining_q - 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q <= speed_q + quo_s[SW-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						idle_q  <= idle_nxt;
						en_q    <= en_nxt;
						dir_q   <= dir_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= s_tuser;
			neg_q <= diff[NW-1];
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_tdata_q <= {3'b000, en_nxt, cmd_nxt, dir_nxt, step_freq, step_on};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/ssr_div.sv =====
// Serial restoring divider for the ramp step, one quotient bit per cycle.
// Unsigned dividend of NUM_W bits by a DIVISOR_W-bit divisor; uses ssr_pkg.
`timescale 1ns / 1ps

module ssr_div
	import ssr_pkg::*;
#(
	parameter int NUM_W = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [NUM_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [NUM_W-1:0]     quo_q;

	logic [DIVISOR_W:0] shifted;
	logic [DIVISOR_W:0] diff;
	logic               ge;

	// Bring down the next dividend bit and try one subtraction.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== verif/stepper_speed_ramp_test.sv =====
// Self-checking testbench for the stepper speed ramp: drives ramp commands and ticks,
// predicts every step result in a scoreboard class and compares field by field.
// Depends on ssr_pkg and stepper_speed_ramp.
`timescale 1ns / 1ps

module stepper_speed_ramp_test;
	import ssr_pkg::*;

	localparam int FRAC          = FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES = FRAC_BITS_DEF + 24;
	localparam int STALL_LIMIT   = 4000;
	localparam int LONG_HOLD     = 500;

	typedef struct {
		logic            step_on;
		logic [15:0]     step_freq;
		logic            direction;
		drv_cmd_t        driver_cmd;
		logic            driver_enabled;
	} step_result_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_THIRDS, RX_HOLD} rx_mode_t;

	class ramp_scoreboard;
		logic [DEADBAND_W-1:0] deadband;
		logic [IDLE_W-1:0]     idle_limit;
		longint                speed_q;
		int                    target;
		int                    remaining;
		logic [IDLE_W-1:0]     idle_count;
		logic                  dir_reg;
		logic                  enabled_reg;
		step_result_t          expected_steps[$];
		int                    errors;

		function new();
			deadband    = DEADBAND_RST;
			idle_limit  = IDLE_LIMIT_RST;
			speed_q     = 0;
			target      = 0;
			remaining   = 0;
			idle_count  = '0;
			dir_reg     = 1'b0;
			enabled_reg = 1'b1;
			errors      = 0;
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_DEADBAND: begin
					deadband = val[DEADBAND_W-1:0];
				end
				REG_IDLE_LIMIT: begin
					idle_limit = val[IDLE_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Step outputs for the current speed; the direction is only updated
		// outside the deadband.
		function step_result_t step_outputs(drv_cmd_t cmd);
			step_result_t r;
			longint whole;
			longint band;
			longint mag;
			whole = speed_q / (longint'(1) << FRAC);
			band = longint'(deadband);
			mag = (whole < 0) ? -whole : whole;
			r.step_on = 1'b0;
			r.step_freq = '0;
			if (whole > band) begin
				r.step_on = 1'b1;
				r.step_freq = mag[15:0];
				dir_reg = 1'b0;
			end else if (whole < -band) begin
				r.step_on = 1'b1;
				r.step_freq = mag[15:0];
				dir_reg = 1'b1;
			end
			r.direction = dir_reg;
			r.driver_cmd = cmd;
			r.driver_enabled = enabled_reg;
			return r;
		endfunction

		function void predict_request(logic op, logic [15:0] ramp, logic [15:0] tgt);
			longint tq;
			drv_cmd_t cmd;
			if (op == OP_LOAD) begin
				remaining = ramp[15] ? 0 : int'(ramp);
				target = int'($signed(tgt));
				expected_steps.push_back(step_outputs(DRV_NONE));
				return;
			end
			tq = longint'(target) * (longint'(1) << FRAC);
			if (remaining != 0)
				speed_q = speed_q + (tq - speed_q) / longint'(remaining);
			else
				speed_q = tq;
			if (remaining > 0)
				remaining--;
			cmd = DRV_NONE;
			if (speed_q == 0) begin
				if (idle_count >= idle_limit) begin
					enabled_reg = 1'b0;
					cmd = DRV_DISABLE;
				end else begin
					idle_count = idle_count + 1'b1;
				end
			end else begin
				idle_count = '0;
				enabled_reg = 1'b1;
				cmd = DRV_ENABLE;
			end
			expected_steps.push_back(step_outputs(cmd));
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("%0t: %s mismatch: observed %0d, predicted %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_step_result(logic [23:0] d);
			step_result_t want;
			if (expected_steps.size() == 0) begin
				report_mismatch("result with none outstanding", int'(d), 0);
				return;
			end
			want = expected_steps.pop_front();
			if (d[0] !== want.step_on)
				report_mismatch("step_on", int'(d[0]), int'(want.step_on));
			if (d[16:1] !== want.step_freq)
				report_mismatch("step_freq", int'(d[16:1]), int'(want.step_freq));
			if (d[17] !== want.direction)
				report_mismatch("direction", int'(d[17]), int'(want.direction));
			if (d[19:18] !== want.driver_cmd)
				report_mismatch("driver_cmd", int'(d[19:18]), int'(want.driver_cmd));
			if (d[20] !== want.driver_enabled)
				report_mismatch("driver_enabled", int'(d[20]), int'(want.driver_enabled));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;    // ramp_ticks[15:0], target_speed[31:16]
	logic                  s_tuser;    // op
	logic                  m_tvalid;
	logic                  m_tready;
	// step_on[0], step_freq[16:1], direction[17], driver_cmd[19:18],
	// driver_enabled[20], zero pad[23:21]
	logic [23:0]           m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ramp_scoreboard sb = new();
	int  burst_left = 0;
	bit  hold_req = 1'b0;
	int  quiet_cycles = 0;

	stepper_speed_ramp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Between bursts the sender drops valid for a random gap and scrambles the bus.
	task pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			s_tuser <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task send_request(logic op, logic [15:0] ramp, logic [15:0] tgt);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {tgt, ramp};
		do @(posedge clk); while (!s_tready);
		sb.predict_request(op, ramp, tgt);
		pace_sender();
	endtask

	task send_tick();
		send_request(OP_TICK, 16'($urandom), 16'($urandom));
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, val);
	endtask

	task set_registers(logic [CFG_DATA_W-1:0] band, logic [IDLE_W-1:0] limit, bit stray);
		write_reg(REG_DEADBAND, band);
		if (stray)
			write_reg(CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));
		write_reg(REG_IDLE_LIMIT, {8'($urandom), limit});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every result is back, then lets the block fall idle.
	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly whole ramps (a command then ticks) with random content, plus noise
	// and ramps cut short by the next command.
	task run_ramps(int count);
		int sent;
		int ticks;
		int tgt_i;
		int sel;
		int limit;
		logic [15:0] ramp;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(1'($urandom), 16'($urandom), 16'($urandom));
				sent++;
				continue;
			end
			case ($urandom_range(0, 7))
				0: ramp = 16'h8000 | 16'($urandom);
				1: ramp = 16'($urandom_range(0, 32767));
				default: ramp = 16'($urandom_range(0, 24));
			endcase
			sel = $urandom_range(0, 4);
			case (sel)
				0: tgt_i = int'($urandom);
				1: tgt_i = $urandom_range(0, 100) - 50;
				2: tgt_i = 0;
				3: tgt_i = (int'(sb.deadband) + $urandom_range(0, 2) - 1)
					* (($urandom_range(0, 1) == 0) ? 1 : -1);
				default: tgt_i = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
			endcase
			if (!ramp[15] && ramp <= 16'd24)
				ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, int'(ramp))
					: int'(ramp) + $urandom_range(0, 3);
			else
				ticks = $urandom_range(1, 30);
			if (sel == 2) begin
				limit = int'(sb.idle_limit);
				if ($urandom_range(0, 9) == 0)
					ticks += limit + 3;
				else
					ticks += $urandom_range(0, (limit < 17) ? limit + 3 : 20);
			end
			send_request(OP_LOAD, ramp, tgt_i[15:0]);
			repeat (ticks) send_tick();
			sent += ticks + 1;
		end
	endtask

	// Receiver: segments of different ready patterns, one long hold on request.
	initial begin
		int seg;
		int n;
		bit held;
		rx_mode_t mode;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			seg = $urandom_range(5, 80);
			mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_req && !held) begin
				held = 1'b1;
				seg = LONG_HOLD;
				mode = RX_HOLD;
			end
			for (n = 0; n < seg; n++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom);
					RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
					RX_THIRDS: m_tready <= (n % 3 == 0);
					default:   m_tready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_step_result(m_tdata);
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: deadband 30, idle limit 200.
		send_tick();
		send_request(OP_LOAD, 16'd0, 16'h7FFF);
		send_tick();
		// A negative count jumps straight to the target on the next tick.
		send_request(OP_LOAD, 16'hFFFF, 16'h8000);
		send_tick();
		send_request(OP_LOAD, 16'h7FFF, 16'h7FFF);
		send_tick();
		send_tick();
		send_request(OP_LOAD, 16'h8000, 16'd30);
		send_tick();
		send_request(OP_LOAD, 16'd0, -16'sd31);
		send_tick();
		send_request(OP_LOAD, 16'd0, 16'd31);
		send_tick();
		// Inside the deadband the direction keeps its last value.
		send_request(OP_LOAD, 16'd0, -16'sd30);
		send_tick();
		send_request(OP_LOAD, 16'd4, 16'd0);
		repeat (6) send_tick();
		drain();

		set_registers(16'd0, 8'd0, 1'b0);
		run_ramps(225);
		drain();

		// Upper deadband bit is dropped by the register width.
		set_registers(16'hFFFF, 8'd255, 1'b1);
		hold_req = 1'b1;
		run_ramps(225);
		drain();

		set_registers(16'($urandom_range(0, 100)), 8'($urandom_range(1, 8)), 1'b1);
		run_ramps(225);
		drain();

		set_registers(16'($urandom_range(0, 300)), 8'd5, 1'b0);
		run_ramps(225);
		drain();

		set_registers(CFG_DATA_W'(DEADBAND_RST), IDLE_LIMIT_RST, 1'b1);
		run_ramps(225);
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
